/* hw/rtl/rsfv_pkg.sv */
`timescale 1ns / 1ps

package rsfv_pkg;

   localparam int NUM_SRC     = 3;
   localparam int VALUE_WIDTH = 64;
   localparam int SEQ_WIDTH   = 64;
   localparam int AGE_WIDTH   = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // queue between front and back
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [1:0] FUNC_TICK    = 2'd0;
   localparam logic [1:0] FUNC_COMPARE = 2'd1;
   localparam logic [1:0] FUNC_COMBINE = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_SOURCE_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STALE_LIMIT  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOWNSELECT   = 2'd2;

   localparam logic [SEQ_WIDTH-1:0] SEQ_INVALID = {1'b1, {(SEQ_WIDTH-1){1'b0}}};

   // bits of a 64-bit result above the element width
   localparam logic [63:0] VAL_EXT_MASK = ~({64{1'b1}} >> (64 - VALUE_WIDTH));

   typedef struct packed {
      logic [1:0]         func;
      logic signed [63:0] fresh_a;
      logic signed [63:0] fresh_b;
      logic signed [63:0] fresh_c;
      logic               use_sequence;
      logic signed [63:0] accepted_seq;
      logic [63:0]        value_a;
      logic [63:0]        value_b;
      logic [63:0]        value_c;
      logic               is_signed;
   } req_type;

   typedef struct packed {
      logic [2:0]  connected_mask;
      logic        any_connected;
      logic [63:0] result_value;
      logic        value_written;
      logic        b_c_agree;
   } rsp_type;

   typedef struct packed {
      logic [1:0]           source_count;
      logic [AGE_WIDTH-1:0] stale_limit;
      logic                 downselect_mode;
   } cfg_type;

   typedef struct packed {
      logic [1:0]             func;
      logic [NUM_SRC-1:0]     live_mask;
      logic                   b_c_equal;
      logic [VALUE_WIDTH-1:0] val_a;
      logic [VALUE_WIDTH-1:0] val_b;
      logic [VALUE_WIDTH-1:0] val_c;
      logic                   is_signed;
   } q_entry_type;

endpackage

/* hw/rtl/rsfv_front.sv */
`timescale 1ns / 1ps

module rsfv_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [rsfv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rsfv_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                         req_valid,
   input  rsfv_pkg::req_type            req_data,
   input  logic                         q_full,
   output logic                         req_stall,
   output logic                         push,
   output rsfv_pkg::q_entry_type        push_entry,
   output rsfv_pkg::cfg_type            cfg
);

   rsfv_pkg::cfg_type cfg_ff;

   logic [rsfv_pkg::SEQ_WIDTH-1:0] last_fresh_ff [rsfv_pkg::NUM_SRC];
   logic [rsfv_pkg::SEQ_WIDTH-1:0] last_fresh_in [rsfv_pkg::NUM_SRC];
   logic [rsfv_pkg::AGE_WIDTH-1:0] fresh_age_ff  [rsfv_pkg::NUM_SRC];
   logic [rsfv_pkg::AGE_WIDTH-1:0] fresh_age_in  [rsfv_pkg::NUM_SRC];
   logic [rsfv_pkg::SEQ_WIDTH-1:0] fresh         [rsfv_pkg::NUM_SRC];
   logic [rsfv_pkg::NUM_SRC-1:0]   updated;
   logic [rsfv_pkg::NUM_SRC-1:0]   live_mask_ff;
   logic [rsfv_pkg::NUM_SRC-1:0]   live_mask_in;
   logic                           b_c_equal_ff;
   logic                           b_c_equal_in;
   logic                           accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign cfg       = cfg_ff;

   assign fresh[0] = req_data.fresh_a;
   assign fresh[1] = req_data.fresh_b;
   assign fresh[2] = req_data.fresh_c;

   always_comb begin
      live_mask_in = live_mask_ff;
      b_c_equal_in = b_c_equal_ff;
      updated      = '0;
      for (int i = 0; i < rsfv_pkg::NUM_SRC; i++) begin
         last_fresh_in[i] = last_fresh_ff[i];
         fresh_age_in[i]  = fresh_age_ff[i];
      end
      unique case (req_data.func)
         rsfv_pkg::FUNC_TICK: begin
            live_mask_in = '0;
            b_c_equal_in = 1'b1;
            for (int i = 0; i < rsfv_pkg::NUM_SRC; i++) begin
               if (2'(i) < cfg_ff.source_count) begin
                  // zero and the most negative counter never count as an update
                  if (fresh[i] != '0 && fresh[i] != rsfv_pkg::SEQ_INVALID) begin
                     updated[i] = req_data.use_sequence ?
                                  (fresh[i] == req_data.accepted_seq) :
                                  (fresh[i] != last_fresh_ff[i]);
                  end
                  if (updated[i]) begin
                     last_fresh_in[i] = fresh[i];
                     fresh_age_in[i]  = '0;
                  end else if (fresh_age_ff[i] < cfg_ff.stale_limit) begin
                     fresh_age_in[i] = fresh_age_ff[i] + 1'b1;
                  end
                  live_mask_in[i] = fresh_age_in[i] < cfg_ff.stale_limit;
               end
            end
         end
         rsfv_pkg::FUNC_COMPARE: begin
            if (req_data.value_b[rsfv_pkg::VALUE_WIDTH-1:0] !=
                req_data.value_c[rsfv_pkg::VALUE_WIDTH-1:0])
               b_c_equal_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      push                 = accept;
      push_entry.func      = req_data.func;
      push_entry.live_mask = live_mask_in;
      push_entry.b_c_equal = b_c_equal_in;
      push_entry.val_a     = req_data.value_a[rsfv_pkg::VALUE_WIDTH-1:0];
      push_entry.val_b     = req_data.value_b[rsfv_pkg::VALUE_WIDTH-1:0];
      push_entry.val_c     = req_data.value_c[rsfv_pkg::VALUE_WIDTH-1:0];
      push_entry.is_signed = req_data.is_signed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_count    <= 2'd3;
         cfg_ff.stale_limit     <= rsfv_pkg::AGE_WIDTH'(1);
         cfg_ff.downselect_mode <= 1'b0;
         live_mask_ff           <= '0;
         b_c_equal_ff           <= 1'b1;
         for (int i = 0; i < rsfv_pkg::NUM_SRC; i++) begin
            last_fresh_ff[i] <= rsfv_pkg::SEQ_INVALID;
            fresh_age_ff[i]  <= rsfv_pkg::AGE_WIDTH'(1);
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               rsfv_pkg::CSR_SOURCE_COUNT: cfg_ff.source_count    <= csr_wdata[1:0];
               rsfv_pkg::CSR_STALE_LIMIT:  cfg_ff.stale_limit     <= csr_wdata;
               rsfv_pkg::CSR_DOWNSELECT:   cfg_ff.downselect_mode <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            live_mask_ff <= live_mask_in;
            b_c_equal_ff <= b_c_equal_in;
            for (int i = 0; i < rsfv_pkg::NUM_SRC; i++) begin
               last_fresh_ff[i] <= last_fresh_in[i];
               fresh_age_ff[i]  <= fresh_age_in[i];
            end
         end
      end
   end

`ifndef SYNTHESIS
   // after a tick, the A mask bit is set exactly when A is in use and younger than the limit
   a_live_fresh: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.func == rsfv_pkg::FUNC_TICK) |=>
         (live_mask_ff[0] == ((fresh_age_ff[0] < $past(cfg_ff.stale_limit)) &&
                              ($past(cfg_ff.source_count) != 2'd0))))
      else $error("source A mask bit disagrees with its age");
`endif

endmodule

/* hw/rtl/rsfv_queue.sv */
`timescale 1ns / 1ps

module rsfv_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  rsfv_pkg::q_entry_type push_entry,
   input  logic                  pop,
   output logic                  q_full,
   output logic                  q_valid,
   output rsfv_pkg::q_entry_type q_head
);

   rsfv_pkg::q_entry_type        slot_ff [rsfv_pkg::Q_DEPTH];
   logic [rsfv_pkg::Q_PTR_W-1:0] wr_ptr_ff;
   logic [rsfv_pkg::Q_PTR_W-1:0] rd_ptr_ff;
   logic [rsfv_pkg::Q_CNT_W-1:0] count_ff;

   assign q_full  = count_ff == rsfv_pkg::Q_CNT_W'(rsfv_pkg::Q_DEPTH);
   assign q_valid = count_ff != '0;
   assign q_head  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push)
            wr_ptr_ff <= (wr_ptr_ff == rsfv_pkg::Q_PTR_W'(rsfv_pkg::Q_DEPTH - 1)) ?
                         '0 : wr_ptr_ff + 1'b1;
         if (pop)
            rd_ptr_ff <= (rd_ptr_ff == rsfv_pkg::Q_PTR_W'(rsfv_pkg::Q_DEPTH - 1)) ?
                         '0 : rd_ptr_ff + 1'b1;
         priority if (push && !pop)
            count_ff <= count_ff + 1'b1;
         else if (pop && !push)
            count_ff <= count_ff - 1'b1;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("queue pop while empty");
`endif

endmodule

/* hw/rtl/rsfv_back.sv */
`timescale 1ns / 1ps

module rsfv_back (
   input  logic                  clock,
   input  logic                  reset,
   input  rsfv_pkg::cfg_type     cfg,
   input  logic                  q_valid,
   input  rsfv_pkg::q_entry_type q_head,
   output logic                  pop,
   output logic                  rsp_valid,
   output rsfv_pkg::rsp_type     rsp_data,
   input  logic                  rsp_stall
);

   function automatic logic val_less(input logic [rsfv_pkg::VALUE_WIDTH-1:0] a,
                                     input logic [rsfv_pkg::VALUE_WIDTH-1:0] b,
                                     input logic sgn);
      logic [rsfv_pkg::VALUE_WIDTH-1:0] flip;
      flip = {sgn, {(rsfv_pkg::VALUE_WIDTH-1){1'b0}}};
      return (a ^ flip) < (b ^ flip);
   endfunction

   logic                             rsp_valid_ff;
   rsfv_pkg::rsp_type                rsp_ff;
   rsfv_pkg::rsp_type                rsp_in;
   logic [1:0]                       n_live;
   logic [rsfv_pkg::VALUE_WIDTH-1:0] first_val;
   logic [rsfv_pkg::VALUE_WIDTH-1:0] second_val;
   logic [rsfv_pkg::VALUE_WIDTH-1:0] max_val;
   logic [rsfv_pkg::VALUE_WIDTH-1:0] med_val;
   logic [rsfv_pkg::VALUE_WIDTH-1:0] pick;
   logic                             a_lt_b;
   logic                             b_lt_c;
   logic                             a_lt_c;
   logic [63:0]                      pick_ext;

   assign pop       = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      n_live = 2'($countones(q_head.live_mask));
      first_val = q_head.live_mask[0] ? q_head.val_a :
                  q_head.live_mask[1] ? q_head.val_b : q_head.val_c;
      // with two live, the second one is B only for the pair A and B
      second_val = (q_head.live_mask == 3'b011) ? q_head.val_b : q_head.val_c;
      max_val = val_less(first_val, second_val, q_head.is_signed) ?
                second_val : first_val;

      a_lt_b = val_less(q_head.val_a, q_head.val_b, q_head.is_signed);
      b_lt_c = val_less(q_head.val_b, q_head.val_c, q_head.is_signed);
      a_lt_c = val_less(q_head.val_a, q_head.val_c, q_head.is_signed);
      // B sits between A and C, else C sits between A and B, else A is the middle
      if (a_lt_b == b_lt_c)
         med_val = q_head.val_b;
      else if (a_lt_c != b_lt_c)
         med_val = q_head.val_c;
      else
         med_val = q_head.val_a;

      priority if (cfg.downselect_mode)
         pick = (n_live == 2'd3) ? (q_head.b_c_equal ? q_head.val_b : q_head.val_a) :
                first_val;
      else if (n_live == 2'd1)
         pick = first_val;
      else if (n_live == 2'd2)
         pick = max_val;
      else
         pick = med_val;

      pick_ext = 64'(pick);
      if (q_head.is_signed && pick[rsfv_pkg::VALUE_WIDTH-1])
         pick_ext = pick_ext | rsfv_pkg::VAL_EXT_MASK;

      rsp_in.connected_mask = q_head.live_mask;
      rsp_in.any_connected  = |q_head.live_mask;
      rsp_in.b_c_agree      = q_head.b_c_equal;
      rsp_in.value_written  = (q_head.func == rsfv_pkg::FUNC_COMBINE) && (n_live != 2'd0);
      rsp_in.result_value   = rsp_in.value_written ? pick_ext : 64'd0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (pop)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (pop)
         rsp_ff <= rsp_in;
   end

`ifndef SYNTHESIS
   a_written_needs_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.value_written) |-> rsp_ff.any_connected)
      else $error("value written with no source connected");
   a_quiet_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.value_written) |-> (rsp_ff.result_value == 64'd0))
      else $error("nonzero result on an unwritten beat");
`endif

endmodule

/* hw/rtl/redundant_source_freshness_voter.sv */
`timescale 1ns / 1ps

// channel   ports                         direction  beat
// request   req_valid req_stall req_data  in         one tick, compare or combine item
// response  rsp_valid rsp_stall rsp_data  out        mask, flag and combined value
// config    csr_we csr_index csr_wdata    in         one register write, no read-back
//
// One item per cycle sustained while rsp_stall is low; an accepted request beat
// is written into the queue, then popped into the output register that drives rsp_valid.
// The front stage applies the tick and compare state updates in the accept cycle,
// so the next item sees them at once. The back stage picks copy, max or median
// from three parallel compares, or B, A or copy in downselect mode, and holds the
// result in an output register; a two-entry queue sits between them.
// Reset (synchronous) marks all sources stale and empties the queue; no clearing pass.
// req_stall rises only when the queue is full, so a stalled response side
// backs up into the request side after two more beats.

module redundant_source_freshness_voter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [rsfv_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rsfv_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rsfv_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rsfv_pkg::rsp_type                rsp_data
);

   rsfv_pkg::cfg_type     cfg;
   rsfv_pkg::q_entry_type push_entry;
   rsfv_pkg::q_entry_type q_head;
   logic                  push;
   logic                  pop;
   logic                  q_full;
   logic                  q_valid;

   // classify and update source state
   rsfv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .q_full     (q_full),
      .req_stall  (req_stall),
      .push       (push),
      .push_entry (push_entry),
      .cfg        (cfg)
   );

   // decouple the two sides
   rsfv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .q_full     (q_full),
      .q_valid    (q_valid),
      .q_head     (q_head)
   );

   // vote and drive the response beat
   rsfv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import rsfv_pkg::*;

   // codes the package leaves unnamed
   localparam logic [1:0]             FUNC_RESERVED = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED  = 2'd3;

   localparam logic [63:0] VAL_MASK = ~VAL_EXT_MASK;
   localparam logic [63:0] VAL_SIGN = 64'd1 << (VALUE_WIDTH - 1);
   localparam logic [63:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam int HOLD_CYCLES  = 60;
   localparam int SEG_ITEMS    = 86;
   localparam int SEG_COUNT    = 6;
   localparam int LIMIT_CYCLES = 200000;
   localparam int MAX_REPORTS  = 40;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_data;

   redundant_source_freshness_voter u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // shadow copy of the voter: registers and per-source freshness state
   logic [1:0]           sh_src_count;
   logic [AGE_WIDTH-1:0] sh_stale_limit;
   logic                 sh_downselect;
   logic [63:0]          sh_last_fresh [NUM_SRC];
   logic [AGE_WIDTH-1:0] sh_age [NUM_SRC];
   logic [NUM_SRC-1:0]   sh_live;
   logic                 sh_bc_equal;

   // expected response beats, oldest first
   rsp_type pending_votes [$];

   int beats_sent   = 0;
   int votes_seen   = 0;
   int csr_writes   = 0;
   int mismatches   = 0;

   // idle odds in percent per cycle, changed by the stimulus between phases
   int send_idle_pct = 34;
   int recv_idle_pct = 70;

   // long receiver hold-off: the stimulus bumps hold_ask, the receiver counts
   int hold_ask  = 0;
   int hold_seen = 0;
   int hold_left = 0;

   // per-source freshness counters that the frame generator walks forward
   logic [63:0] gen_cnt [NUM_SRC];

   function automatic logic val_less(input logic [63:0] a, input logic [63:0] b,
                                     input logic sgn);
      logic [63:0] x;
      logic [63:0] y;
      x = a & VAL_MASK;
      y = b & VAL_MASK;
      if (sgn) begin
         x ^= VAL_SIGN;
         y ^= VAL_SIGN;
      end
      return x < y;
   endfunction

   // Work out the response beat of one accepted request beat and advance the
   // shadow state exactly as the block does in its accept cycle.
   function automatic rsp_type vote_predict(input req_type r);
      rsp_type     o;
      logic [63:0] v [NUM_SRC];
      logic [63:0] f [NUM_SRC];
      logic [63:0] pick;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mid;
      logic        upd;
      int          n;
      int          first;
      int          second;
      o      = '0;
      n      = 0;
      first  = 0;
      second = 0;
      v[0] = r.value_a & VAL_MASK;
      v[1] = r.value_b & VAL_MASK;
      v[2] = r.value_c & VAL_MASK;
      f[0] = r.fresh_a;
      f[1] = r.fresh_b;
      f[2] = r.fresh_c;
      case (r.func)
         FUNC_TICK: begin
            sh_live = '0;
            for (int i = 0; i < NUM_SRC; i++) begin
               if (i < sh_src_count) begin
                  // zero and the most negative counter never count as an update
                  upd = 1'b0;
                  if (f[i] != 64'd0 && f[i] != SEQ_INVALID)
                     upd = r.use_sequence ? (f[i] == r.accepted_seq)
                                          : (f[i] != sh_last_fresh[i]);
                  if (upd) begin
                     sh_last_fresh[i] = f[i];
                     sh_age[i]        = '0;
                  end else if (sh_age[i] < sh_stale_limit) begin
                     sh_age[i] = sh_age[i] + 1'b1;
                  end
                  if (sh_age[i] < sh_stale_limit)
                     sh_live[i] = 1'b1;
               end
            end
            sh_bc_equal = 1'b1;
         end
         FUNC_COMPARE: begin
            if (v[1] != v[2])
               sh_bc_equal = 1'b0;
         end
         FUNC_COMBINE: begin
            for (int i = 0; i < NUM_SRC; i++) begin
               if (sh_live[i]) begin
                  if (n == 0)
                     first = i;
                  else if (n == 1)
                     second = i;
                  n++;
               end
            end
            if (n > 0) begin
               if (sh_downselect) begin
                  pick = (n == 3) ? (sh_bc_equal ? v[1] : v[0]) : v[first];
               end else if (n == 1) begin
                  pick = v[first];
               end else if (n == 2) begin
                  pick = val_less(v[first], v[second], r.is_signed) ? v[second] : v[first];
               end else begin
                  lo   = val_less(v[1], v[0], r.is_signed) ? v[1] : v[0];
                  hi   = val_less(v[0], v[1], r.is_signed) ? v[1] : v[0];
                  mid  = val_less(v[2], hi, r.is_signed) ? v[2] : hi;
                  pick = val_less(lo, mid, r.is_signed) ? mid : lo;
               end
               pick &= VAL_MASK;
               if (r.is_signed && pick[VALUE_WIDTH-1])
                  pick |= ~VAL_MASK;
               o.result_value  = pick;
               o.value_written = 1'b1;
            end
         end
         default: ;
      endcase
      o.connected_mask = sh_live;
      o.any_connected  = |sh_live;
      o.b_c_agree      = sh_bc_equal;
      return o;
   endfunction

   // ------------------------------------------------------------------
   // Receiver: check every accepted response beat, then pick the next stall.
   // ------------------------------------------------------------------
   task automatic report_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endtask

   task automatic check_vote(input rsp_type got);
      rsp_type want;
      if (pending_votes.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: response beat with nothing expected, expected none, actual %h",
                     $time, got);
         return;
      end
      want = pending_votes.pop_front();
      votes_seen++;
      report_field("connected_mask", 64'(want.connected_mask), 64'(got.connected_mask));
      report_field("any_connected",  64'(want.any_connected),  64'(got.any_connected));
      report_field("result_value",   want.result_value,        got.result_value);
      report_field("value_written",  64'(want.value_written),  64'(got.value_written));
      report_field("b_c_agree",      64'(want.b_c_agree),      64'(got.b_c_agree));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         check_vote(rsp_data);
      // a requested hold-off keeps stall high for its whole count
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_ask != hold_seen) begin
         hold_seen <= hold_ask;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------

   // Offer one request beat, idling first at random; return right after the
   // edge that accepted it. Queue the expected response at that edge.
   task automatic send_beat(input req_type b, input bit typed, input rsp_type want);
      rsp_type p;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      do @(posedge clock); while (req_stall);
      beats_sent++;
      // advance the shadow state even where the row types its own answer
      p = vote_predict(b);
      pending_votes.insert(pending_votes.size(), typed ? want : p);
   endtask

   task automatic push_beat(input req_type b);
      send_beat(b, 1'b0, '0);
   endtask

   // Drain, then write one register; the block is idle while it lands.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      req_valid <= 1'b0;
      while (pending_votes.size() != 0) @(posedge clock);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      csr_writes++;
      case (idx)
         CSR_SOURCE_COUNT: sh_src_count   = data[1:0];
         CSR_STALE_LIMIT:  sh_stale_limit = data;
         CSR_DOWNSELECT:   sh_downselect  = data[0];
         default: ;
      endcase
   endtask

   // Program all three registers; junk in the unused upper bits must be dropped.
   task automatic program_voter(input logic [1:0] src, input logic [7:0] stale,
                                input logic ds);
      logic [7:0] junk;
      junk = 8'($urandom);
      csr_write(CSR_SOURCE_COUNT, {junk[7:2], src});
      csr_write(CSR_STALE_LIMIT, stale);
      junk = 8'($urandom);
      csr_write(CSR_DOWNSELECT, {junk[7:1], ds});
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // element value: corners, small numbers of either sign, or anything
   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 64'd0;
         1:       return ALL_ONES;
         2:       return SEQ_INVALID;
         3:       return MOST_POS;
         4:       return 64'($urandom_range(0, 4));
         5:       return -64'($urandom_range(1, 4));
         default: return rand64();
      endcase
   endfunction

   // every field random, the reserved func included
   function automatic req_type noise_beat();
      req_type b;
      b.func         = 2'($urandom_range(0, 3));
      b.fresh_a      = rand64();
      b.fresh_b      = rand64();
      b.fresh_c      = rand64();
      b.use_sequence = 1'($urandom_range(0, 1));
      b.accepted_seq = rand64();
      b.value_a      = rand64();
      b.value_b      = rand64();
      b.value_c      = rand64();
      b.is_signed    = 1'($urandom_range(0, 1));
      return b;
   endfunction

   // Tick with counters that mostly move on, sometimes stand still, and now
   // and then carry one of the two invalid codes.
   function automatic req_type gen_tick();
      req_type     b;
      logic [63:0] f [NUM_SRC];
      b = noise_beat();
      b.func = FUNC_TICK;
      for (int i = 0; i < NUM_SRC; i++) begin
         case ($urandom_range(0, 11))
            0, 1, 2, 3, 4, 5, 6: begin
               gen_cnt[i] = gen_cnt[i] + 64'($urandom_range(1, 3));
               f[i] = gen_cnt[i];
            end
            7, 8:    f[i] = gen_cnt[i];
            9:       f[i] = 64'd0;
            10:      f[i] = SEQ_INVALID;
            default: begin
               gen_cnt[i] = rand64();
               f[i] = gen_cnt[i];
            end
         endcase
      end
      b.fresh_a = f[0];
      b.fresh_b = f[1];
      b.fresh_c = f[2];
      b.use_sequence = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0)
         b.accepted_seq = f[$urandom_range(0, 2)];
      return b;
   endfunction

   // element beat; values cluster around a base so medians are not trivial
   function automatic req_type gen_elem(input logic [1:0] fn);
      req_type     b;
      logic [63:0] base;
      b = noise_beat();
      b.func = fn;
      base = pick_value();
      b.value_a = ($urandom_range(0, 2) == 0) ? base + 64'($urandom_range(0, 2)) : pick_value();
      b.value_b = ($urandom_range(0, 2) == 0) ? base - 64'($urandom_range(0, 2)) : pick_value();
      b.value_c = ($urandom_range(0, 1) == 0) ? b.value_b : pick_value();
      return b;
   endfunction

   // one frame: a tick, some B/C compares, some combines; or a burst of noise
   task automatic send_frame();
      int k;
      if ($urandom_range(0, 9) == 0) begin
         k = $urandom_range(1, 3);
         repeat (k) push_beat(noise_beat());
      end else begin
         push_beat(gen_tick());
         k = $urandom_range(0, 2);
         repeat (k) push_beat(gen_elem(FUNC_COMPARE));
         k = $urandom_range(1, 4);
         repeat (k) push_beat(gen_elem(FUNC_COMBINE));
      end
   endtask

   // ------------------------------------------------------------------
   // Directed table
   // ------------------------------------------------------------------
   typedef enum logic {ROW_WRITE, ROW_BEAT} row_kind_type;

   typedef struct {
      row_kind_type           kind;
      logic [CSR_INDEX_W-1:0] idx;
      logic [CSR_DATA_W-1:0]  wdata;
      req_type                beat;
      bit                     typed;
      rsp_type                want;
   } dir_row_type;

   dir_row_type dir_rows [$];

   function automatic req_type mk_tick(input logic [63:0] fa, input logic [63:0] fb,
                                       input logic [63:0] fc, input logic useq,
                                       input logic [63:0] seq);
      req_type b;
      b = '0;
      b.func         = FUNC_TICK;
      b.fresh_a      = fa;
      b.fresh_b      = fb;
      b.fresh_c      = fc;
      b.use_sequence = useq;
      b.accepted_seq = seq;
      return b;
   endfunction

   function automatic req_type mk_elem(input logic [1:0] fn, input logic [63:0] va,
                                       input logic [63:0] vb, input logic [63:0] vc,
                                       input logic sgn);
      req_type b;
      b = '0;
      b.func      = fn;
      b.value_a   = va;
      b.value_b   = vb;
      b.value_c   = vc;
      b.is_signed = sgn;
      return b;
   endfunction

   function automatic rsp_type mk_want(input logic [2:0] mask, input logic [63:0] val,
                                       input logic wr, input logic bc);
      rsp_type o;
      o.connected_mask = mask;
      o.any_connected  = |mask;
      o.result_value   = val;
      o.value_written  = wr;
      o.b_c_agree      = bc;
      return o;
   endfunction

   function automatic void add_write(input logic [CSR_INDEX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      dir_row_type r;
      r.kind  = ROW_WRITE;
      r.idx   = idx;
      r.wdata = data;
      r.beat  = '0;
      r.typed = 1'b0;
      r.want  = '0;
      dir_rows.insert(dir_rows.size(), r);
   endfunction

   function automatic void add_beat(input req_type b, input bit typed, input rsp_type want);
      dir_row_type r;
      r.kind  = ROW_BEAT;
      r.idx   = '0;
      r.wdata = '0;
      r.beat  = b;
      r.typed = typed;
      r.want  = want;
      dir_rows.insert(dir_rows.size(), r);
   endfunction

   function automatic void build_directed();
      // after reset: every source stale, flag set
      add_beat(mk_elem(FUNC_COMBINE, 64'd1, 64'd2, 64'd3, 1'b0), 1, mk_want(0, 0, 0, 1));
      add_beat(mk_elem(FUNC_RESERVED, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1),
               1, mk_want(0, 0, 0, 1));
      add_beat(mk_elem(FUNC_COMPARE, 64'd0, 64'd1, 64'd2, 1'b0), 1, mk_want(0, 0, 0, 0));
      // first tick: all counters differ from the reset value
      add_beat(mk_tick(64'd5, 64'd5, 64'd5, 1'b0, 64'd0), 1, mk_want(7, 0, 0, 1));
      add_beat(mk_elem(FUNC_COMBINE, ALL_ONES, 64'd0, 64'd1, 1'b0),
               1, mk_want(7, 64'd1, 1, 1));
      add_beat(mk_elem(FUNC_COMBINE, SEQ_INVALID, MOST_POS, ALL_ONES, 1'b1),
               1, mk_want(7, ALL_ONES, 1, 1));
      add_beat(mk_elem(FUNC_COMPARE, 64'd9, 64'hA5A5, 64'hA5A5, 1'b0), 0, '0);
      // same counters again: age reaches the limit of one, all stale
      add_beat(mk_tick(64'd5, 64'd5, 64'd5, 1'b0, 64'd0), 1, mk_want(0, 0, 0, 1));
      // invalid counters on A and B, a real update on C
      add_beat(mk_tick(64'd0, SEQ_INVALID, 64'd6, 1'b0, 64'd0), 0, '0);
      add_beat(mk_elem(FUNC_COMBINE, 64'd1, 64'd2, 64'd3, 1'b0), 0, '0);
      add_write(CSR_STALE_LIMIT, 8'hFF);
      add_write(CSR_DOWNSELECT, 8'h01);
      // sequence mode, then downselect with the flag cleared and set
      add_beat(mk_tick(64'd9, 64'd9, 64'd8, 1'b1, 64'd9), 0, '0);
      add_beat(mk_elem(FUNC_COMPARE, 64'd0, 64'd1, 64'd2, 1'b0), 0, '0);
      add_beat(mk_elem(FUNC_COMBINE, 64'd11, 64'd22, 64'd33, 1'b0), 0, '0);
      add_beat(mk_tick(64'd10, 64'd0, 64'd10, 1'b1, 64'd10), 0, '0);
      add_beat(mk_elem(FUNC_COMBINE, 64'd11, 64'd22, 64'd33, 1'b0), 0, '0);
      add_write(CSR_SOURCE_COUNT, 8'h02);
      add_write(CSR_DOWNSELECT, 8'h00);
      // two sources: maximum, signed and unsigned
      add_beat(mk_tick(MOST_POS, ALL_ONES, 64'd77, 1'b0, 64'd0), 0, '0);
      add_beat(mk_elem(FUNC_COMBINE, -64'd5, 64'd3, 64'd0, 1'b1), 0, '0);
      add_beat(mk_elem(FUNC_COMBINE, -64'd5, 64'd3, 64'd0, 1'b0), 0, '0);
      // source count changed without a tick: the old mask still rules
      add_write(CSR_SOURCE_COUNT, 8'h01);
      add_beat(mk_elem(FUNC_COMBINE, 64'd40, 64'd50, 64'd60, 1'b0), 0, '0);
      // zero sources in use, zero stale limit
      add_write(CSR_SOURCE_COUNT, 8'h00);
      add_write(CSR_STALE_LIMIT, 8'h00);
      add_beat(mk_tick(64'd1, 64'd2, 64'd3, 1'b0, 64'd0), 1, mk_want(0, 0, 0, 1));
      add_beat(mk_elem(FUNC_COMBINE, 64'd1, 64'd2, 64'd3, 1'b0), 1, mk_want(0, 0, 0, 1));
      add_write(CSR_SOURCE_COUNT, 8'h03);
      add_beat(mk_tick(64'd21, 64'd22, 64'd23, 1'b0, 64'd0), 1, mk_want(0, 0, 0, 1));
      // one source with downselect; the unmapped index must change nothing
      add_write(CSR_SOURCE_COUNT, 8'h01);
      add_write(CSR_STALE_LIMIT, 8'h03);
      add_write(CSR_DOWNSELECT, 8'h01);
      add_write(CSR_UNMAPPED, 8'hA5);
      add_beat(mk_tick(64'd31, 64'd32, 64'd33, 1'b0, 64'd0), 0, '0);
      add_beat(mk_elem(FUNC_COMBINE, 64'hDEAD, 64'hBEEF, 64'hCAFE, 1'b0), 0, '0);
   endfunction

   // ------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("%0t: timeout, %0d response beats still outstanding",
               $time, pending_votes.size());
      $display("TB_ERROR");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int          seg_start;
      bit          pressed;
      bit          paused;
      logic [1:0]  src;
      logic [7:0]  stale;
      logic        ds;

      // shadow state after reset
      sh_src_count   = 2'd3;
      sh_stale_limit = 8'd1;
      sh_downselect  = 1'b0;
      for (int i = 0; i < NUM_SRC; i++) begin
         sh_last_fresh[i] = SEQ_INVALID;
         sh_age[i]        = 8'd1;
         gen_cnt[i]       = 64'($urandom_range(1, 1000));
      end
      sh_live     = '0;
      sh_bc_equal = 1'b1;
      pressed     = 1'b0;
      paused      = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under the first idle pattern
      build_directed();
      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_WRITE)
            csr_write(dir_rows[i].idx, dir_rows[i].wdata);
         else
            send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
      end

      // random part: two register settings per idle pattern
      for (int s = 0; s < SEG_COUNT; s++) begin
         case (s)
            0: begin src = 2'd3; stale = 8'd1;   ds = 1'b0; end
            1: begin src = 2'd3; stale = 8'd255; ds = 1'b1; end
            2: begin src = 2'd2; stale = 8'd3;   ds = 1'b0; end
            3: begin src = 2'd1; stale = 8'd2;   ds = 1'b1; end
            4: begin src = 2'd3; stale = 8'($urandom_range(1, 6)); ds = 1'b0; end
            default: begin
               src   = 2'($urandom_range(0, 3));
               stale = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 8)) : 8'($urandom);
               ds    = 1'($urandom_range(0, 1));
            end
         endcase
         if (s == 2) begin
            send_idle_pct = 70;
            recv_idle_pct = 34;
         end else if (s == 4) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         program_voter(src, stale, ds);
         seg_start = beats_sent;
         while (beats_sent - seg_start < SEG_ITEMS) begin
            send_frame();
            // hold the response side off while beats keep coming
            if (s == 4 && !pressed && beats_sent - seg_start > 30) begin
               hold_ask <= hold_ask + 1;
               pressed = 1'b1;
            end
            // pause the request side until every response is in
            if (s == 5 && !paused && beats_sent - seg_start > 40) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (pending_votes.size() != 0);
               paused = 1'b1;
            end
         end
      end

      // drain and let a few more cycles pass for any stray response beat
      req_valid <= 1'b0;
      while (pending_votes.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);

      $display("voter run: %0d request beats, %0d response beats checked, %0d register writes",
               beats_sent, votes_seen, csr_writes);
      $display("covered all funcs, 0..3 sources, stale limits 0..255, both modes, long hold-off");
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
